// ===== hdl/three_axis_thermal_correction_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef THREE_AXIS_THERMAL_CORRECTION_MACROS_SVH
`define THREE_AXIS_THERMAL_CORRECTION_MACROS_SVH

// Same-cycle implication.
`define TATC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define TATC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/tatc_pkg.sv =====
package tatc_pkg;

   localparam int WordsPerEntry = 19;
   localparam int SlotScale     = 12;
   localparam int SlotId        = 18;
   localparam int SampleSteps   = 18;

   localparam logic [31:0] OneQ824   = 32'h0100_0000;
   localparam logic [7:0]  Unmapped  = 8'hFF;
   localparam logic [16:0] OneDegree = 17'd256;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_LOAD   = 2'd1,
      KIND_BIND   = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_DISABLED  = 3'd0,
      STATUS_CORRECTED = 3'd1,
      STATUS_MOVED     = 3'd2,
      STATUS_UNMAPPED  = 3'd3,
      STATUS_BOUND     = 3'd4,
      STATUS_NOMATCH   = 3'd5,
      STATUS_LOADED    = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SAMPLE,
      FSM_SFIN,
      FSM_BIND,
      FSM_DONE
   } fsm_type;

   typedef enum logic [2:0] {
      PH_REF,
      PH_MIN,
      PH_MAX,
      PH_LEAD,
      PH_HORNER,
      PH_SCALE
   } phase_type;

   typedef struct packed {
      logic [4:0] slot;
      logic [1:0] axis;
      phase_type  phase;
   } step_info_type;

   typedef struct packed {
      logic       en;
      logic [1:0] entry;
      logic [4:0] slot;
   } mem_rd_type;

   typedef struct packed {
      logic        en;
      logic [1:0]  entry;
      logic [4:0]  slot;
      logic [31:0] data;
   } mem_wr_type;

   // Read schedule of a sample: reference, range, then per axis the
   // coefficients from the cubic down and the scale.
   function automatic step_info_type step_info(input logic [4:0] step);
      step_info_type r;
      case (step)
         5'd0:    r = '{5'd15, 2'd0, PH_REF};
         5'd1:    r = '{5'd16, 2'd0, PH_MIN};
         5'd2:    r = '{5'd17, 2'd0, PH_MAX};
         5'd3:    r = '{5'd3,  2'd0, PH_LEAD};
         5'd4:    r = '{5'd2,  2'd0, PH_HORNER};
         5'd5:    r = '{5'd1,  2'd0, PH_HORNER};
         5'd6:    r = '{5'd0,  2'd0, PH_HORNER};
         5'd7:    r = '{5'd12, 2'd0, PH_SCALE};
         5'd8:    r = '{5'd7,  2'd1, PH_LEAD};
         5'd9:    r = '{5'd6,  2'd1, PH_HORNER};
         5'd10:   r = '{5'd5,  2'd1, PH_HORNER};
         5'd11:   r = '{5'd4,  2'd1, PH_HORNER};
         5'd12:   r = '{5'd13, 2'd1, PH_SCALE};
         5'd13:   r = '{5'd11, 2'd2, PH_LEAD};
         5'd14:   r = '{5'd10, 2'd2, PH_HORNER};
         5'd15:   r = '{5'd9,  2'd2, PH_HORNER};
         5'd16:   r = '{5'd8,  2'd2, PH_HORNER};
         5'd17:   r = '{5'd14, 2'd2, PH_SCALE};
         default: r = '{5'd15, 2'd0, PH_REF};
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/tatc_cal_mem.sv =====
module tatc_cal_mem #(
   parameter int ENTRIES = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  tatc_pkg::mem_wr_type wr,
   input  tatc_pkg::mem_rd_type rd,
   output logic [31:0]         rd_data
);
   import tatc_pkg::*;

   localparam int Depth = ENTRIES * WordsPerEntry;
   localparam int AW    = $clog2(Depth);

   logic [31:0]   mem [Depth];
   logic [Depth-1:0] valid_ff;
   logic [31:0]   rd_data_ff;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   assign wr_addr = AW'(int'(wr.entry) * WordsPerEntry + int'(wr.slot));
   assign rd_addr = AW'(int'(rd.entry) * WordsPerEntry + int'(rd.slot));
   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Unwritten words read as reset contents: zero, scales one.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         if (valid_ff[rd_addr]) begin
            rd_data_ff <= mem[rd_addr];
         end else if (int'(rd.slot) >= SlotScale && int'(rd.slot) < SlotScale + 3) begin
            rd_data_ff <= OneQ824;
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

endmodule

// ===== hdl/three_axis_thermal_correction.sv =====
// Channel | Direction | Transfer when         | Payload
// req     | in        | req_valid & req_ready | kind, instance, temperature, samples, load word
// rsp     | out       | rsp_valid & rsp_ready | status, clamp flag, corrected/offset/scale, entry
// csr     | in        | csr_wr_en             | enable bit
// A sample makes 18 reads of the calibration memory, one word per cycle, with one shared
// Horner multiplier, then passes the read, scale, finish and output stages. A bind reads
// the ID word of each entry until a match or the last entry; a load and all bypass cases
// go straight to the output. The next transfer can be taken in the cycle the result appears.
// Reset clears the memory valid bits, the instance map and the last temperatures.
// One item at a time; a finished result waits in the output register while
// the next transfer is accepted, and work stalls at the end if it is still full.
module three_axis_thermal_correction #(
   parameter int ENTRIES   = 3,
   parameter int INSTANCES = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [1:0]         req_instance_req,
   input  logic signed [15:0] req_temperature,
   input  logic signed [31:0] req_sample_x,
   input  logic signed [31:0] req_sample_y,
   input  logic signed [31:0] req_sample_z,
   input  logic [1:0]         req_entry_index,
   input  logic [4:0]         req_word_slot,
   input  logic signed [31:0] req_word_value,
   input  logic [31:0]        req_device_id,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic               rsp_temp_clamped,
   output logic signed [31:0] rsp_corrected_x,
   output logic signed [31:0] rsp_corrected_y,
   output logic signed [31:0] rsp_corrected_z,
   output logic signed [31:0] rsp_offset_x,
   output logic signed [31:0] rsp_offset_y,
   output logic signed [31:0] rsp_offset_z,
   output logic signed [31:0] rsp_scale_x,
   output logic signed [31:0] rsp_scale_y,
   output logic signed [31:0] rsp_scale_z,
   output logic [1:0]         rsp_bound_entry,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data
);
   import tatc_pkg::*;

   localparam int IW = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;

   fsm_type state_ff, state_in;

   logic enable_ff;

   // Latched item
   logic [1:0]         inst_ff;
   logic signed [15:0] temp_ff;
   logic signed [31:0] smp_ff [3];
   logic [31:0]        dev_ff;
   logic [1:0]         entry_ff;

   // Sequencer
   logic [4:0] iss_ff;
   logic       proc_vld_ff;
   logic [4:0] proc_step_ff;

   // Arithmetic
   logic signed [15:0] ref_ff;
   logic signed [15:0] min_ff;
   logic signed [16:0] d_ff;
   logic signed [31:0] acc_ff;
   logic signed [31:0] dv_ff;
   logic               mul_pend_ff;
   logic [1:0]         mul_axis_ff;

   // Result being built
   logic [2:0]         res_status_ff;
   logic               res_clamped_ff;
   logic signed [31:0] res_corr_ff [3];
   logic signed [31:0] res_off_ff [3];
   logic signed [31:0] res_scl_ff [3];
   logic [1:0]         res_bound_ff;

   // Per-instance state
   logic [7:0]         map_ff [INSTANCES];
   logic signed [15:0] last_ff [INSTANCES];

   // Output register
   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic               rsp_clamped_ff;
   logic signed [31:0] rsp_corr_ff [3];
   logic signed [31:0] rsp_off_ff [3];
   logic signed [31:0] rsp_scl_ff [3];
   logic [1:0]         rsp_bound_ff;

   mem_rd_type  mem_rd;
   mem_wr_type  mem_wr;
   logic [31:0] rd_data;

   logic               req_xfer;
   logic               is_sample;
   logic               inst_ok;
   logic [7:0]         map_val;
   logic               map_ok;
   logic signed [16:0] tdiff;
   logic [16:0]        tdist;
   logic               moved;
   logic               go_sample;
   logic               go_bind;
   step_info_type      pinfo;
   step_info_type      iinfo;
   logic signed [15:0] rd_t16;
   logic signed [31:0] rd_w32;
   logic signed [48:0] hprod;
   logic [63:0]        hsum;
   logic signed [31:0] horner;
   logic signed [31:0] off;
   logic [63:0]        dvw;
   logic signed [63:0] sprod;
   logic signed [31:0] corr;
   logic               match;
   logic               last_entry;
   logic               out_free;

   tatc_cal_mem #(.ENTRIES(ENTRIES)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (rd_data)
   );

   // Decode the offered item
   always_comb begin
      req_xfer  = req_valid && req_ready;
      is_sample = kind_type'(req_kind) == KIND_SAMPLE;
      inst_ok   = 32'(req_instance_req) < INSTANCES;
      map_val   = inst_ok ? map_ff[req_instance_req[IW-1:0]] : Unmapped;
      map_ok    = 32'(map_val) < ENTRIES;
      tdiff     = 17'(req_temperature) - 17'(last_ff[req_instance_req[IW-1:0]]);
      tdist     = tdiff[16] ? 17'(-tdiff) : 17'(tdiff);
      moved     = tdist > OneDegree;
      go_sample = enable_ff && inst_ok && map_ok;
      go_bind   = enable_ff && inst_ok;
   end

   // Datapath values for the word coming back from memory
   always_comb begin
      pinfo      = step_info(proc_step_ff);
      iinfo      = step_info(iss_ff);
      rd_t16     = rd_data[15:0];
      rd_w32     = rd_data;
      hprod      = acc_ff * d_ff;
      hsum       = {{23{hprod[48]}}, hprod[48:8]} + {{32{rd_w32[31]}}, rd_w32};
      horner     = sat32(hsum);
      off        = {{8{acc_ff[31]}}, acc_ff[31:8]};
      dvw        = {{32{smp_ff[pinfo.axis][31]}}, smp_ff[pinfo.axis]}
                   - {{32{off[31]}}, off};
      sprod      = dv_ff * res_scl_ff[mul_axis_ff];
      corr       = sat32({{24{sprod[63]}}, sprod[63:24]});
      match      = rd_data == dev_ff;
      last_entry = 32'(proc_step_ff) == ENTRIES - 1;
      out_free   = !rsp_valid_ff || rsp_ready;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_xfer) begin
               case (kind_type'(req_kind))
                  KIND_SAMPLE: state_in = go_sample ? FSM_SAMPLE : FSM_DONE;
                  KIND_BIND:   state_in = go_bind ? FSM_BIND : FSM_DONE;
                  default:     state_in = FSM_DONE;
               endcase
            end
         end
         FSM_SAMPLE: begin
            if (proc_vld_ff && 32'(proc_step_ff) == SampleSteps - 1) begin
               state_in = FSM_SFIN;
            end
         end
         FSM_SFIN: state_in = FSM_DONE;
         FSM_BIND: begin
            if (proc_vld_ff && (match || last_entry)) begin
               state_in = FSM_DONE;
            end
         end
         FSM_DONE: begin
            if (out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // Control outputs: handshake and memory ports
   always_comb begin
      req_ready = state_ff == FSM_IDLE;
      mem_rd    = '0;
      case (state_ff)
         FSM_SAMPLE: begin
            mem_rd.en    = 32'(iss_ff) < SampleSteps;
            mem_rd.entry = entry_ff;
            mem_rd.slot  = iinfo.slot;
         end
         FSM_BIND: begin
            mem_rd.en    = 32'(iss_ff) < ENTRIES;
            mem_rd.entry = iss_ff[1:0];
            mem_rd.slot  = 5'(SlotId);
         end
         default: mem_rd = '0;
      endcase
      // Loads write straight from the port on the transfer edge
      mem_wr.en    = req_xfer && kind_type'(req_kind) == KIND_LOAD
                     && 32'(req_entry_index) < ENTRIES
                     && 32'(req_word_slot) < WordsPerEntry;
      mem_wr.entry = req_entry_index;
      mem_wr.slot  = req_word_slot;
      mem_wr.data  = req_word_value;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         enable_ff    <= 1'b0;
         iss_ff       <= '0;
         proc_vld_ff  <= 1'b0;
         mul_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < INSTANCES; i++) begin
            map_ff[i]  <= Unmapped;
            last_ff[i] <= 16'sh8000;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
         if (req_xfer) begin
            iss_ff <= '0;
         end else if (mem_rd.en) begin
            iss_ff <= iss_ff + 5'd1;
         end
         proc_vld_ff <= mem_rd.en;
         mul_pend_ff <= state_ff == FSM_SAMPLE && proc_vld_ff && pinfo.phase == PH_SCALE;
         // Remember the temperature of a mapped sample that moved
         if (req_xfer && is_sample && go_sample && moved) begin
            last_ff[req_instance_req[IW-1:0]] <= req_temperature;
         end
         if (state_ff == FSM_BIND && proc_vld_ff && match) begin
            map_ff[inst_ff[IW-1:0]] <= 8'(proc_step_ff);
         end
         if (state_ff == FSM_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload and arithmetic
   always_ff @(posedge clock) begin
      proc_step_ff <= iss_ff;
      if (req_xfer) begin
         inst_ff        <= req_instance_req;
         temp_ff        <= req_temperature;
         smp_ff[0]      <= req_sample_x;
         smp_ff[1]      <= req_sample_y;
         smp_ff[2]      <= req_sample_z;
         dev_ff         <= req_device_id;
         entry_ff       <= map_val[1:0];
         res_clamped_ff <= 1'b0;
         res_bound_ff   <= '0;
         for (int a = 0; a < 3; a++) begin
            res_off_ff[a] <= '0;
         end
         // Samples start from the pass-through values; other kinds leave zeros
         res_corr_ff[0] <= is_sample ? req_sample_x : '0;
         res_corr_ff[1] <= is_sample ? req_sample_y : '0;
         res_corr_ff[2] <= is_sample ? req_sample_z : '0;
         for (int a = 0; a < 3; a++) begin
            res_scl_ff[a] <= is_sample ? OneQ824 : '0;
         end
         case (kind_type'(req_kind))
            KIND_SAMPLE: begin
               if (!enable_ff) begin
                  res_status_ff <= STATUS_DISABLED;
               end else if (!go_sample) begin
                  res_status_ff <= STATUS_UNMAPPED;
               end else begin
                  res_status_ff <= moved ? STATUS_MOVED : STATUS_CORRECTED;
               end
            end
            KIND_LOAD: res_status_ff <= STATUS_LOADED;
            KIND_BIND: res_status_ff <= enable_ff ? STATUS_NOMATCH : STATUS_DISABLED;
            default:   res_status_ff <= STATUS_DISABLED;
         endcase
      end

      if (state_ff == FSM_SAMPLE && proc_vld_ff) begin
         case (pinfo.phase)
            PH_REF: ref_ff <= rd_t16;
            PH_MIN: min_ff <= rd_t16;
            PH_MAX: begin
               // Test the maximum first, then the minimum
               if (temp_ff > rd_t16) begin
                  d_ff           <= 17'(rd_t16) - 17'(ref_ff);
                  res_clamped_ff <= 1'b1;
               end else if (temp_ff < min_ff) begin
                  d_ff           <= 17'(min_ff) - 17'(ref_ff);
                  res_clamped_ff <= 1'b1;
               end else begin
                  d_ff <= 17'(temp_ff) - 17'(ref_ff);
               end
            end
            PH_LEAD:   acc_ff <= rd_w32;
            PH_HORNER: acc_ff <= horner;
            PH_SCALE: begin
               res_off_ff[pinfo.axis] <= off;
               res_scl_ff[pinfo.axis] <= rd_w32;
               dv_ff                  <= sat32(dvw);
               mul_axis_ff            <= pinfo.axis;
            end
            default: acc_ff <= acc_ff;
         endcase
      end

      // Apply the scale in the cycle after the difference is ready
      if (mul_pend_ff) begin
         res_corr_ff[mul_axis_ff] <= corr;
      end

      if (state_ff == FSM_BIND && proc_vld_ff && match) begin
         res_status_ff <= STATUS_BOUND;
         res_bound_ff  <= proc_step_ff[1:0];
      end

      if (state_ff == FSM_DONE && out_free) begin
         rsp_status_ff  <= res_status_ff;
         rsp_clamped_ff <= res_clamped_ff;
         rsp_bound_ff   <= res_bound_ff;
         for (int a = 0; a < 3; a++) begin
            rsp_corr_ff[a] <= res_corr_ff[a];
            rsp_off_ff[a]  <= res_off_ff[a];
            rsp_scl_ff[a]  <= res_scl_ff[a];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_temp_clamped = rsp_clamped_ff;
   assign rsp_corrected_x  = rsp_corr_ff[0];
   assign rsp_corrected_y  = rsp_corr_ff[1];
   assign rsp_corrected_z  = rsp_corr_ff[2];
   assign rsp_offset_x     = rsp_off_ff[0];
   assign rsp_offset_y     = rsp_off_ff[1];
   assign rsp_offset_z     = rsp_off_ff[2];
   assign rsp_scale_x      = rsp_scl_ff[0];
   assign rsp_scale_y      = rsp_scl_ff[1];
   assign rsp_scale_z      = rsp_scl_ff[2];
   assign rsp_bound_entry  = rsp_bound_ff;

endmodule

// ===== hdl/tatc_checker.sv =====
`include "three_axis_thermal_correction_macros.svh"

module tatc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         rsp_status,
   input logic               rsp_temp_clamped,
   input logic signed [31:0] rsp_corrected_x,
   input logic signed [31:0] rsp_offset_x,
   input logic signed [31:0] rsp_offset_y,
   input logic signed [31:0] rsp_offset_z
);
   import tatc_pkg::*;

   `TATC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))
   `TATC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   `TATC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `TATC_ASSERT_IMPL(a_disabled_no_offset, clock, reset, rsp_valid && rsp_status == STATUS_DISABLED, rsp_offset_x == 0 && rsp_offset_y == 0 && rsp_offset_z == 0)
   `TATC_ASSERT_IMPL(a_load_clean, clock, reset, rsp_valid && rsp_status == STATUS_LOADED, rsp_corrected_x == 0 && !rsp_temp_clamped)

endmodule

bind three_axis_thermal_correction tatc_checker u_tatc_checker (.*);
